[sv/assert_macros.svh]
// Assertion macros shared by the RTL of the checked integer parser.
// Depends on nothing; the including module must have i_clk and i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every rising edge while out of reset.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication checked on every rising edge while out of reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication checked while out of reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[sv/cip_pkg.sv]
// Package of the checked integer parser: types, constants and the digit decoder.
// Depends on nothing; used by checked_integer_parser_top.
`timescale 1ns / 1ps
`default_nettype none

package cip_pkg;

    localparam int unsigned MAX_CHARS_DEF = 11;
    localparam int unsigned CH_W          = 8;
    localparam int unsigned VALUE_W       = 31;
    localparam int unsigned ERR_W         = 2;
    localparam int unsigned DIGIT_W       = 4;
    localparam int unsigned BASE_W        = 5;

    localparam logic [VALUE_W-1:0] VALUE_MAX = {VALUE_W{1'b1}};

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_ONE   = 8'h31;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_LC_A  = 8'h61;
    localparam logic [CH_W-1:0] CH_LC_F  = 8'h66;
    localparam logic [CH_W-1:0] CH_UC_A  = 8'h41;
    localparam logic [CH_W-1:0] CH_UC_F  = 8'h46;
    localparam logic [CH_W-1:0] CH_LC_X  = 8'h78;
    localparam logic [CH_W-1:0] CH_UC_X  = 8'h58;

    localparam logic [BASE_W-1:0] BASE_OCT = 5'd8;
    localparam logic [BASE_W-1:0] BASE_DEC = 5'd10;
    localparam logic [BASE_W-1:0] BASE_HEX = 5'd16;

    typedef enum logic [ERR_W-1:0] {
        ERR_NONE     = 2'd0,
        ERR_TOO_LONG = 2'd1,
        ERR_BAD_HEAD = 2'd2,
        ERR_GARBAGE  = 2'd3
    } t_err;

    typedef enum logic [6:0] {
        MODE_START = 7'b000_0001,
        MODE_ZERO  = 7'b000_0010,
        MODE_ZEROX = 7'b000_0100,
        MODE_HEX   = 7'b000_1000,
        MODE_OCT   = 7'b001_0000,
        MODE_DEC   = 7'b010_0000,
        MODE_STOP  = 7'b100_0000
    } t_mode;

    typedef struct packed {
        logic               valid;
        logic [DIGIT_W-1:0] value;
    } t_digit;

    // Decodes c as a digit of the given base; valid is low when the base cannot take it.
    function automatic t_digit digit_of(input logic [CH_W-1:0] c,
                                        input logic [BASE_W-1:0] base);
        t_digit             d;
        logic [CH_W-1:0]    diff;
        d    = '0;
        diff = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            diff    = c - CH_ZERO;
            d.valid = 1'b1;
            d.value = diff[DIGIT_W-1:0];
        end else if (c >= CH_LC_A && c <= CH_LC_F) begin
            diff    = c - CH_LC_A + 8'd10;
            d.valid = 1'b1;
            d.value = diff[DIGIT_W-1:0];
        end else if (c >= CH_UC_A && c <= CH_UC_F) begin
            diff    = c - CH_UC_A + 8'd10;
            d.valid = 1'b1;
            d.value = diff[DIGIT_W-1:0];
        end
        if ({1'b0, d.value} >= base) begin
            d.valid = 1'b0;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

[sv/checked_integer_parser_top.sv]
// Checked integer parser: streams ASCII characters in, gives one parse result per string.
// Depends on cip_pkg and assert_macros.svh.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+----------------------------------
//  input   | in        | i_in_valid / o_in_ready    | i_ch (one character, NUL ends)
//  result  | out       | o_out_valid / i_out_ready  | o_ok, o_value, o_error_code
//
// One character is taken in every cycle unless the input stalls. A character is first captured in the input
// register and is then worked on by the character update (a shift-add by 8, 10 or 16 with
// saturation, plus the base-mode logic); a NUL also loads the result register when it moves
// on from the input register, and the result waits there until it is taken.
// Reset (synchronous, active low) empties both registers and returns the parse state to
// the start of a string. Input stalls only when a NUL waits in the input register while
// the result register still holds a transaction not yet taken; ordinary characters flow on.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module checked_integer_parser_top #(
    parameter int unsigned MAX_CHARS = cip_pkg::MAX_CHARS_DEF
) (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_in_valid,
    output logic                              o_in_ready,
    input  wire logic [cip_pkg::CH_W-1:0]     i_ch,
    output logic                              o_out_valid,
    input  wire logic                         i_out_ready,
    output logic                              o_ok,
    output logic      [cip_pkg::VALUE_W-1:0]  o_value,
    output logic      [cip_pkg::ERR_W-1:0]    o_error_code
);

    // The count saturates at one past the limit, so it must be able to hold MAX_CHARS + 1.
    localparam int unsigned CNT_W = $clog2(MAX_CHARS + 2);
    localparam int unsigned PROD_W = cip_pkg::VALUE_W + 4;
    localparam int unsigned SUM_W  = PROD_W + 1;

    // Input register.
    logic                         r_in_valid;
    logic [cip_pkg::CH_W-1:0]     r_ch;

    // Parse state.
    logic [CNT_W-1:0]             r_count, n_count;
    logic [cip_pkg::VALUE_W-1:0]  r_acc, n_acc;
    cip_pkg::t_mode               r_mode, n_mode;
    logic                         r_first_bad, n_first_bad;
    logic                         r_garbage, n_garbage;

    // Result register.
    logic                         r_out_valid;
    logic                         r_ok, n_ok;
    logic [cip_pkg::VALUE_W-1:0]  r_value, n_value;
    cip_pkg::t_err                r_err, n_err;

    logic                         w_is_nul;
    logic                         w_adv;
    logic                         w_load;
    logic [cip_pkg::BASE_W-1:0]   w_base;
    cip_pkg::t_digit              w_dig;
    cip_pkg::t_digit              w_dig_oct;
    cip_pkg::t_digit              w_dig_hex;
    logic [PROD_W-1:0]            w_prod;
    logic [SUM_W-1:0]             w_sum;
    logic [cip_pkg::VALUE_W-1:0]  w_mac;
    logic                         w_ok_agrees;
    logic                         w_at_start;

    assign w_is_nul   = (r_ch == cip_pkg::CH_NUL);
    // The character stage moves unless a NUL would overwrite a result still waiting.
    assign w_adv      = r_in_valid && !(w_is_nul && r_out_valid && !i_out_ready);
    assign w_load     = w_adv && w_is_nul;
    assign o_in_ready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_ch <= i_ch;
        end
    end

    // Base of the current digit run; only used in the three running modes.
    always_comb begin
        unique case (r_mode)
            cip_pkg::MODE_HEX: w_base = cip_pkg::BASE_HEX;
            cip_pkg::MODE_OCT: w_base = cip_pkg::BASE_OCT;
            default:           w_base = cip_pkg::BASE_DEC;
        endcase
    end

    assign w_dig     = cip_pkg::digit_of(r_ch, w_base);
    assign w_dig_oct = cip_pkg::digit_of(r_ch, cip_pkg::BASE_OCT);
    assign w_dig_hex = cip_pkg::digit_of(r_ch, cip_pkg::BASE_HEX);

    // Multiply by the base as shifts: x16, x8, or x8 + x2.
    always_comb begin
        unique case (r_mode)
            cip_pkg::MODE_HEX: w_prod = {r_acc, 4'b0000};
            cip_pkg::MODE_OCT: w_prod = {1'b0, r_acc, 3'b000};
            default:           w_prod = {1'b0, r_acc, 3'b000} + {3'b000, r_acc, 1'b0};
        endcase
    end

    assign w_sum = {1'b0, w_prod} + {{(SUM_W - cip_pkg::DIGIT_W){1'b0}}, w_dig.value};
    assign w_mac = (w_sum[SUM_W-1:cip_pkg::VALUE_W] != '0) ? cip_pkg::VALUE_MAX
                                                           : w_sum[cip_pkg::VALUE_W-1:0];

    always_comb begin
        n_count     = r_count;
        n_acc       = r_acc;
        n_mode      = r_mode;
        n_first_bad = r_first_bad;
        n_garbage   = r_garbage;
        n_ok        = r_ok;
        n_value     = r_value;
        n_err       = r_err;
        if (w_adv) begin
            if (w_is_nul) begin
                // End of string: error checks by priority, then back to the start.
                if (r_count > CNT_W'(MAX_CHARS)) begin
                    n_err = cip_pkg::ERR_TOO_LONG;
                end else if (r_first_bad || r_mode == cip_pkg::MODE_START) begin
                    n_err = cip_pkg::ERR_BAD_HEAD;
                end else if (r_garbage || r_mode == cip_pkg::MODE_ZEROX) begin
                    n_err = cip_pkg::ERR_GARBAGE;
                end else begin
                    n_err = cip_pkg::ERR_NONE;
                end
                n_ok        = (n_err == cip_pkg::ERR_NONE);
                n_value     = n_ok ? r_acc : '0;
                n_count     = '0;
                n_acc       = '0;
                n_mode      = cip_pkg::MODE_START;
                n_first_bad = 1'b0;
                n_garbage   = 1'b0;
            end else begin
                if (r_count <= CNT_W'(MAX_CHARS)) begin
                    n_count = r_count + 1'b1;
                end
                unique case (r_mode)
                    cip_pkg::MODE_START: begin
                        if (r_ch == cip_pkg::CH_ZERO) begin
                            n_acc  = '0;
                            n_mode = cip_pkg::MODE_ZERO;
                        end else if (r_ch >= cip_pkg::CH_ONE && r_ch <= cip_pkg::CH_NINE) begin
                            n_acc  = cip_pkg::VALUE_W'(w_dig_hex.value);
                            n_mode = cip_pkg::MODE_DEC;
                        end else begin
                            n_first_bad = 1'b1;
                            n_mode      = cip_pkg::MODE_STOP;
                        end
                    end
                    cip_pkg::MODE_ZERO: begin
                        if (r_ch == cip_pkg::CH_LC_X || r_ch == cip_pkg::CH_UC_X) begin
                            n_mode = cip_pkg::MODE_ZEROX;
                        end else if (w_dig_oct.valid) begin
                            n_acc  = cip_pkg::VALUE_W'(w_dig_oct.value);
                            n_mode = cip_pkg::MODE_OCT;
                        end else begin
                            n_garbage = 1'b1;
                            n_mode    = cip_pkg::MODE_STOP;
                        end
                    end
                    cip_pkg::MODE_ZEROX: begin
                        if (w_dig_hex.valid) begin
                            n_acc  = cip_pkg::VALUE_W'(w_dig_hex.value);
                            n_mode = cip_pkg::MODE_HEX;
                        end else begin
                            n_garbage = 1'b1;
                            n_mode    = cip_pkg::MODE_STOP;
                        end
                    end
                    cip_pkg::MODE_HEX, cip_pkg::MODE_OCT, cip_pkg::MODE_DEC: begin
                        if (w_dig.valid) begin
                            n_acc = w_mac;
                        end else begin
                            n_garbage = 1'b1;
                            n_mode    = cip_pkg::MODE_STOP;
                        end
                    end
                    cip_pkg::MODE_STOP: begin
                        n_mode = cip_pkg::MODE_STOP;
                    end
                    default: begin
                        n_mode = cip_pkg::MODE_STOP;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_acc       <= '0;
            r_mode      <= cip_pkg::MODE_START;
            r_first_bad <= 1'b0;
            r_garbage   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_count     <= n_count;
            r_acc       <= n_acc;
            r_mode      <= n_mode;
            r_first_bad <= n_first_bad;
            r_garbage   <= n_garbage;
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_ok    <= n_ok;
        r_value <= n_value;
        r_err   <= n_err;
    end

    assign o_out_valid  = r_out_valid;
    assign o_ok         = r_ok;
    assign o_value      = r_value;
    assign o_error_code = r_err;

    assign w_ok_agrees = (o_ok == (o_error_code == cip_pkg::ERR_NONE));
    assign w_at_start  = (r_mode == cip_pkg::MODE_START) && (r_count == '0) && (r_acc == '0);

    // A result is good exactly when it carries no error code, and a failed one reads zero.
    `ASSERT_IMPL(a_ok_matches_err, o_out_valid, w_ok_agrees, "ok and error code disagree")
    `ASSERT_IMPL(a_err_value_zero, o_out_valid && !o_ok, o_value == '0, "failed result not zero")
    // Finishing a string leaves the parse state as it was after reset.
    `ASSERT_NEXT(a_nul_restarts, w_load, w_at_start, "state not restarted after end of string")
    // A held NUL never drops a waiting result.
    `ASSERT_CLK(a_no_overwrite, !(w_load && r_out_valid && !i_out_ready), "result overwritten")

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for checked_integer_parser_top: strings of ASCII characters go in,
// and each parse result is compared with a cycle-free predictor kept in this module.
// Depends on cip_pkg and the RTL of checked_integer_parser_top.
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CHAR_LIMIT     = cip_pkg::MAX_CHARS_DEF;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          TAIL_CYCLES    = 10;
    localparam int          HOLD_CYCLES    = 400;

    // One expected parse result, in the same shape as the result channel.
    typedef struct packed {
        logic                        ok;
        logic [cip_pkg::VALUE_W-1:0] value;
        cip_pkg::t_err               err;
    } t_parse_result;

    logic                         i_clk        = 1'b0;
    logic                         i_rst_n      = 1'b0;
    logic                         i_in_valid   = 1'b0;
    logic [cip_pkg::CH_W-1:0]     i_ch         = cip_pkg::CH_NUL;
    logic                         i_out_ready  = 1'b0;
    logic                         o_in_ready;
    logic                         o_out_valid;
    logic                         o_ok;
    logic [cip_pkg::VALUE_W-1:0]  o_value;
    logic [cip_pkg::ERR_W-1:0]    o_error_code;

    // Parse state of the predictor; it mirrors what the block holds between characters.
    int unsigned                  seen_chars;
    logic [cip_pkg::VALUE_W-1:0]  parsed_value;
    cip_pkg::t_mode               parse_mode;
    logic                         head_bad;
    logic                         tail_garbage;

    t_parse_result                pending_results[$];

    int                  failures      = 0;
    int                  chars_sent    = 0;
    int                  send_idle_pct = 0;
    int                  recv_idle_pct = 0;
    int                  hold_request  = 0;
    int                  quiet_cycles  = 0;

    checked_integer_parser_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_ch         (i_ch),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_ok         (o_ok),
        .o_value      (o_value),
        .o_error_code (o_error_code)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic void clear_parse();
        seen_chars   = 0;
        parsed_value = '0;
        parse_mode   = cip_pkg::MODE_START;
        head_bad     = 1'b0;
        tail_garbage = 1'b0;
    endfunction

    // Value of c as a digit of the given base, or -1 when the base cannot take it.
    function automatic int digit_in_base(input logic [cip_pkg::CH_W-1:0] c, input int base);
        int dig;
        dig = -1;
        if (c >= cip_pkg::CH_ZERO && c <= cip_pkg::CH_NINE) begin
            dig = int'(c - cip_pkg::CH_ZERO);
        end else if (c >= cip_pkg::CH_LC_A && c <= cip_pkg::CH_LC_F) begin
            dig = int'(c - cip_pkg::CH_LC_A) + 10;
        end else if (c >= cip_pkg::CH_UC_A && c <= cip_pkg::CH_UC_F) begin
            dig = int'(c - cip_pkg::CH_UC_A) + 10;
        end
        return (dig < base) ? dig : -1;
    endfunction

    function automatic void mark_garbage();
        tail_garbage = 1'b1;
        parse_mode   = cip_pkg::MODE_STOP;
    endfunction

    // Advances the predicted parse by one accepted character; a NUL closes the string
    // and queues the result that the block ought to give for it.
    function automatic void parse_char(input logic [cip_pkg::CH_W-1:0] c);
        t_parse_result res;
        int            dig;
        int            base;
        logic [63:0]   wide;
        if (c == cip_pkg::CH_NUL) begin
            // Length beats a bad head, which beats trailing garbage.
            if (seen_chars > CHAR_LIMIT) begin
                res.err = cip_pkg::ERR_TOO_LONG;
            end else if (head_bad || parse_mode == cip_pkg::MODE_START) begin
                res.err = cip_pkg::ERR_BAD_HEAD;
            end else if (tail_garbage || parse_mode == cip_pkg::MODE_ZEROX) begin
                res.err = cip_pkg::ERR_GARBAGE;
            end else begin
                res.err = cip_pkg::ERR_NONE;
            end
            res.ok    = (res.err == cip_pkg::ERR_NONE);
            res.value = res.ok ? parsed_value : '0;
            pending_results.push_back(res);
            clear_parse();
        end else begin
            if (seen_chars <= CHAR_LIMIT) begin
                seen_chars++;
            end
            case (parse_mode)
                cip_pkg::MODE_START: begin
                    if (c == cip_pkg::CH_ZERO) begin
                        parsed_value = '0;
                        parse_mode   = cip_pkg::MODE_ZERO;
                    end else if (c >= cip_pkg::CH_ONE && c <= cip_pkg::CH_NINE) begin
                        parsed_value = cip_pkg::VALUE_W'(c - cip_pkg::CH_ZERO);
                        parse_mode   = cip_pkg::MODE_DEC;
                    end else begin
                        head_bad   = 1'b1;
                        parse_mode = cip_pkg::MODE_STOP;
                    end
                end
                cip_pkg::MODE_ZERO: begin
                    if (c == cip_pkg::CH_LC_X || c == cip_pkg::CH_UC_X) begin
                        parse_mode = cip_pkg::MODE_ZEROX;
                    end else begin
                        dig = digit_in_base(c, 8);
                        if (dig >= 0) begin
                            parsed_value = cip_pkg::VALUE_W'(dig);
                            parse_mode   = cip_pkg::MODE_OCT;
                        end else begin
                            mark_garbage();
                        end
                    end
                end
                cip_pkg::MODE_ZEROX: begin
                    dig = digit_in_base(c, 16);
                    if (dig >= 0) begin
                        parsed_value = cip_pkg::VALUE_W'(dig);
                        parse_mode   = cip_pkg::MODE_HEX;
                    end else begin
                        mark_garbage();
                    end
                end
                cip_pkg::MODE_HEX, cip_pkg::MODE_OCT, cip_pkg::MODE_DEC: begin
                    base = (parse_mode == cip_pkg::MODE_HEX) ? 16 :
                           (parse_mode == cip_pkg::MODE_OCT) ? 8 : 10;
                    dig  = digit_in_base(c, base);
                    if (dig >= 0) begin
                        // Saturate rather than wrap, and keep consuming digits.
                        wide = 64'(parsed_value) * 64'(base) + 64'(dig);
                        parsed_value = (wide > 64'(cip_pkg::VALUE_MAX)) ?
                                       cip_pkg::VALUE_MAX : wide[cip_pkg::VALUE_W-1:0];
                    end else begin
                        mark_garbage();
                    end
                end
                default: begin
                    // Once stopped, characters are only counted.
                end
            endcase
        end
    endfunction

    // ------------------------------------------------------------------
    // Result side: ready pattern, checking and watchdog
    // ------------------------------------------------------------------

    // The receiver either follows its idle percentage or, when a hold-off is requested,
    // keeps ready low for the requested hold-off, whose length is counted down here and nowhere else.
    initial begin : receiver
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (hold_request != 0) begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0) begin
                hold_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    // Every result transaction is matched against the oldest prediction still waiting.
    always @(posedge i_clk) begin : result_check
        t_parse_result want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with none expected: ok %0d value %0d error %0d",
                         $time, o_ok, o_value, o_error_code);
                failures++;
            end else begin
                want = pending_results.pop_front();
                if (o_ok !== want.ok) begin
                    $display("%0t: ok mismatch: expected %0d actual %0d",
                             $time, want.ok, o_ok);
                    failures++;
                end
                if (o_value !== want.value) begin
                    $display("%0t: value mismatch: expected %0d actual %0d",
                             $time, want.value, o_value);
                    failures++;
                end
                if (o_error_code !== want.err) begin
                    $display("%0t: error code mismatch: expected %0d actual %0d",
                             $time, want.err, o_error_code);
                    failures++;
                end
            end
        end
    end

    // Ends a hung run: counts cycles in which neither channel completes a transaction.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, quiet_cycles);
            $display("Test completed with failures");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------

    // Offers one character and returns just after the edge at which it was taken. Valid is
    // only dropped for an idle gap, so back-to-back transactions keep it high throughout.
    task automatic send_char(input logic [cip_pkg::CH_W-1:0] c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_ch       <= c;
        @(posedge i_clk);
        while (!o_in_ready) begin
            @(posedge i_clk);
        end
        parse_char(c);
        chars_sent++;
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++) begin
            send_char(cip_pkg::CH_W'(s[i]));
        end
        send_char(cip_pkg::CH_NUL);
    endtask

    // Sender pause: nothing is offered until every predicted result has been seen.
    task automatic wait_for_results();
        i_in_valid <= 1'b0;
        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    function automatic logic [cip_pkg::CH_W-1:0] random_hex_char();
        int v;
        v = $urandom_range(0, 15);
        if (v < 10) begin
            return cip_pkg::CH_ZERO + cip_pkg::CH_W'(v);
        end
        return ($urandom_range(0, 1) ? cip_pkg::CH_LC_A : cip_pkg::CH_UC_A)
               + cip_pkg::CH_W'(v - 10);
    endfunction

    // Mostly well-formed decimal, octal and hex numbers with random digits, some of them
    // over-long or with one stray byte, plus a share of pure noise and empty strings.
    task automatic send_random_string();
        int                       kind;
        int                       len;
        int                       bad_pos;
        logic [cip_pkg::CH_W-1:0] c;
        kind    = $urandom_range(0, 99);
        len     = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 14) : $urandom_range(1, 11);
        bad_pos = ($urandom_range(0, 5) == 0) ? $urandom_range(0, len - 1) : -1;
        if (kind >= 97) begin
            len = 0;
        end
        for (int i = 0; i < len; i++) begin
            if (i == bad_pos || kind >= 88) begin
                c = cip_pkg::CH_W'($urandom_range(1, 255));
            end else if (kind < 35) begin
                c = (i == 0) ? cip_pkg::CH_ONE + cip_pkg::CH_W'($urandom_range(0, 8))
                             : cip_pkg::CH_ZERO + cip_pkg::CH_W'($urandom_range(0, 9));
            end else if (kind < 60) begin
                c = (i == 0) ? cip_pkg::CH_ZERO
                             : cip_pkg::CH_ZERO + cip_pkg::CH_W'($urandom_range(0, 7));
            end else if (i == 0) begin
                c = cip_pkg::CH_ZERO;
            end else if (i == 1) begin
                c = $urandom_range(0, 1) ? cip_pkg::CH_LC_X : cip_pkg::CH_UC_X;
            end else begin
                c = random_hex_char();
            end
            send_char(c);
        end
        send_char(cip_pkg::CH_NUL);
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // The special cases one by one: empty string, a sign first, bare and broken hex
    // prefixes, a valid hex value, a nine in octal, saturation at exactly the length
    // limit, one character over it, and a top-bit byte as the head.
    task automatic test_directed();
        send_text("");
        send_text("-7");
        send_text("0x");
        send_text("0Xg");
        send_text("0Xf");
        send_text("079");
        send_text("99999999999");
        send_text("999999999999");
        send_char(8'hFF);
        send_char(cip_pkg::CH_NUL);
        wait_for_results();
    endtask

    task automatic test_random(input int sender_idle, input int receiver_idle,
                               input int char_budget);
        int stop_at;
        send_idle_pct = sender_idle;
        recv_idle_pct = receiver_idle;
        stop_at       = chars_sent + char_budget;
        while (chars_sent < stop_at) begin
            send_random_string();
        end
        wait_for_results();
    endtask

    // The receiver holds off for a long stretch while strings keep coming, so the result
    // register fills, the next NUL waits in the input register and the input stalls.
    task automatic test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = HOLD_CYCLES;
        repeat (40) begin
            send_random_string();
        end
        wait_for_results();
    endtask

    initial begin
        clear_parse();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_random(37, 87, 500);
        test_random(87, 37, 500);
        test_random(0, 0, 250);
        test_backpressure();

        wait_for_results();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (failures == 0 && pending_results.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
